@@ design/lsc_pkg.sv @@
// ----------------------------------------------------------------------------
// lsc_pkg: shared types for the LRU cache tag store
// Op and outcome codes, register indexes, payload structs, count helper.
// ----------------------------------------------------------------------------
package lsc_pkg;

	localparam int TAG_W      = 64;
	localparam int COUNT_W    = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;
	localparam int SET_BITS_W = 3;
	localparam int BLK_BITS_W = 6;
	localparam int WAYS_W     = 4;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_STORE  = 2'd1,
		OP_MODIFY = 2'd2,
		OP_IFETCH = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		OUT_IGNORED = 2'd0,
		OUT_HIT     = 2'd1,
		OUT_MISS    = 2'd2,
		OUT_EVICT   = 2'd3
	} outcome_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SET_BITS    = 2'd0,
		REG_BLOCK_BITS  = 2'd1,
		REG_WAYS_IN_USE = 2'd2
	} reg_idx_t;

	typedef struct packed {
		op_t              op;
		logic [TAG_W-1:0] address;
	} req_t;

	typedef struct packed {
		outcome_t           outcome;
		logic               modify_extra_hit;
		logic [COUNT_W-1:0] hit_count;
		logic [COUNT_W-1:0] miss_count;
		logic [COUNT_W-1:0] eviction_count;
	} rsp_t;

	// add 0..3, sticking at all ones
	function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] cnt,
			input logic [1:0] inc);
		logic [COUNT_W:0] sum;
		sum = {1'b0, cnt} + {{(COUNT_W-1){1'b0}}, inc};
		return sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];
	endfunction

endpackage

@@ design/lsc_req_if.sv @@
// ----------------------------------------------------------------------------
// lsc_req_if: access request channel
// Valid/ready channel carrying op and byte address.
// ----------------------------------------------------------------------------
interface lsc_req_if;
	import lsc_pkg::*;

	logic valid;
	logic ready;
	req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ design/lsc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// lsc_rsp_if: access result channel
// Valid/ready channel carrying outcome and running totals.
// ----------------------------------------------------------------------------
interface lsc_rsp_if;
	import lsc_pkg::*;

	logic valid;
	logic ready;
	rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ design/lru_set_assoc_cache_tags.sv @@
// ----------------------------------------------------------------------------
// lru_set_assoc_cache_tags: set-associative tag store with LRU replacement
// One memory row per set holds valid bits, tags and recency ranks of all ways.
// ----------------------------------------------------------------------------
// Usage:
//   req  - access transfer: op and 64-bit byte address.
//   rsp  - one result per access: outcome, modify flag, hit/miss/evict totals.
//   cfg  - cfg_we/cfg_index/cfg_wdata write set_bits, block_bits, ways_in_use;
//          write only while no access is in flight.
// Timing:
//   The set row is read into a row register at the accept edge; once the output
//   register is free, the row is compared, updated and written back (not for
//   an ifetch) and the result is registered. req.ready stays low from the accept
//   until that edge, so no new access is taken while one is in flight; this
//   serialises the read-modify-write of the set row through the row memory
//   (read port, then write port, before the next read).
// Reset:
//   Totals clear, config returns to set_bits 0, block_bits 0, ways_in_use 1,
//   and a clearing pass writes an empty row into every set, one per cycle,
//   with req.ready low until every set is written. cfg writes are taken meanwhile.
// Stall:
//   A result waiting on rsp does not block the next request transfer; the
//   write-back of that next access waits until the output register frees.
// ----------------------------------------------------------------------------
module lru_set_assoc_cache_tags #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	lsc_req_if.sink                          req,
	lsc_rsp_if.source                        rsp,
	input  logic                             cfg_we,
	input  logic [lsc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lsc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import lsc_pkg::*;

	localparam int DEPTH = 1 << MAX_SET_BITS;
	localparam int IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int REC_W = WAY_W;
	localparam int CNT_W = $clog2(MAX_WAYS + 1);
	localparam int LIM_W = REC_W + 1;
	localparam int TSH_W = 7;
	localparam logic [REC_W-1:0] REC_MAX   = REC_W'(MAX_WAYS - 1);
	localparam logic [LIM_W-1:0] LIM_FILL  = LIM_W'(MAX_WAYS);
	localparam logic [IDX_W-1:0] LAST_ROW  = IDX_W'(DEPTH - 1);

	typedef struct packed {
		logic [MAX_WAYS-1:0]            valid;
		logic [MAX_WAYS-1:0][TAG_W-1:0] tag;
		logic [MAX_WAYS-1:0][REC_W-1:0] rec;
	} row_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} state_t;

	// config
	logic [SET_BITS_W-1:0] set_bits_q;
	logic [BLK_BITS_W-1:0] block_bits_q;
	logic [WAYS_W-1:0]     ways_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= '0;
			block_bits_q <= '0;
			ways_q       <= WAYS_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SET_BITS:    set_bits_q   <= cfg_wdata[SET_BITS_W-1:0];
				REG_BLOCK_BITS:  block_bits_q <= cfg_wdata[BLK_BITS_W-1:0];
				REG_WAYS_IN_USE: ways_q       <= cfg_wdata[WAYS_W-1:0];
				default: ;
			endcase
		end
	end

	// effective geometry
	logic [SET_BITS_W-1:0] sb;
	logic [CNT_W-1:0]      ways_eff;

	always_comb begin
		sb = (32'(set_bits_q) > MAX_SET_BITS) ? SET_BITS_W'(MAX_SET_BITS) : set_bits_q;
		if (ways_q == '0)
			ways_eff = CNT_W'(1);
		else if (32'(ways_q) > MAX_WAYS)
			ways_eff = CNT_W'(MAX_WAYS);
		else
			ways_eff = CNT_W'(ways_q);
	end

	// address split
	logic [TAG_W-1:0] off_sh;
	logic [IDX_W-1:0] req_set;
	logic [TSH_W-1:0] tag_shift;
	logic [TAG_W-1:0] req_tag;

	always_comb begin
		off_sh    = req.payload.address >> block_bits_q;
		req_set   = off_sh[IDX_W-1:0] & ~({IDX_W{1'b1}} << sb);
		tag_shift = TSH_W'(block_bits_q) + TSH_W'(sb);
		req_tag   = (tag_shift >= TSH_W'(TAG_W)) ? '0 : (req.payload.address >> tag_shift);
	end

	state_t           state_q;
	logic [IDX_W-1:0] clr_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	logic [COUNT_W-1:0] hit_q, miss_q, evict_q;

	op_t              op_s1;
	logic [TAG_W-1:0] tag_s1;
	logic [IDX_W-1:0] set_s1;

	logic req_xfer, advance;
	assign req.ready = (state_q == ST_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign advance   = (state_q == ST_LOOKUP) && (!rsp_valid_q || rsp.ready);

	// row memory
	row_t             mem [DEPTH];
	row_t             rd_row_q;
	row_t             new_row;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	row_t             mem_wdata;

	assign mem_we    = (state_q == ST_CLEAR) || (advance && op_s1 != OP_IFETCH);
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : set_s1;
	assign mem_wdata = (state_q == ST_CLEAR) ? row_t'('0) : new_row;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (req_xfer)
			rd_row_q <= mem[req_set];
	end

	// lookup and update of the set row
	logic [MAX_WAYS-1:0] in_use, hit_vec, inv_vec;
	logic                hit, has_inv;
	logic [WAY_W-1:0]    hit_way, inv_way, vic_way, sel_way;
	logic [LIM_W-1:0]    limit;
	outcome_t            outcome;
	logic [1:0]          hit_inc;

	always_comb begin
		for (int i = 0; i < MAX_WAYS; i++) begin
			in_use[i]  = CNT_W'(i) < ways_eff;
			hit_vec[i] = in_use[i] && rd_row_q.valid[i] && (rd_row_q.tag[i] == tag_s1);
			inv_vec[i] = in_use[i] && !rd_row_q.valid[i];
		end
		hit     = |hit_vec;
		has_inv = |inv_vec;

		hit_way = '0;
		inv_way = '0;
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (hit_vec[i])
				hit_way = WAY_W'(i);
			if (inv_vec[i])
				inv_way = WAY_W'(i);
		end

		// highest rank, lowest way on ties
		vic_way = '0;
		for (int i = 1; i < MAX_WAYS; i++) begin
			if (in_use[i] && rd_row_q.rec[i] > rd_row_q.rec[vic_way])
				vic_way = WAY_W'(i);
		end

		new_row = rd_row_q;
		if (hit) begin
			sel_way = hit_way;
			limit   = {1'b0, rd_row_q.rec[hit_way]};
			outcome = OUT_HIT;
		end else if (has_inv) begin
			sel_way = inv_way;
			limit   = LIM_FILL;
			outcome = OUT_MISS;
			new_row.valid[inv_way] = 1'b1;
			new_row.tag[inv_way]   = tag_s1;
		end else begin
			sel_way = vic_way;
			limit   = {1'b0, rd_row_q.rec[vic_way]};
			outcome = OUT_EVICT;
			new_row.tag[vic_way] = tag_s1;
		end

		for (int i = 0; i < MAX_WAYS; i++) begin
			if (in_use[i] && WAY_W'(i) != sel_way && rd_row_q.valid[i] &&
			    {1'b0, rd_row_q.rec[i]} < limit && rd_row_q.rec[i] != REC_MAX)
				new_row.rec[i] = rd_row_q.rec[i] + REC_W'(1);
		end
		new_row.rec[sel_way] = '0;

		if (op_s1 == OP_IFETCH)
			outcome = OUT_IGNORED;
		hit_inc = {1'b0, outcome == OUT_HIT} + {1'b0, op_s1 == OP_MODIFY};
	end

	// control, totals, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
			hit_q       <= '0;
			miss_q      <= '0;
			evict_q     <= '0;
		end else begin
			if (rsp.ready)
				rsp_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == LAST_ROW)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (req_xfer)
						state_q <= ST_LOOKUP;
				end
				ST_LOOKUP: begin
					if (advance) begin
						state_q     <= ST_IDLE;
						rsp_valid_q <= 1'b1;
						hit_q       <= sat_add(hit_q, hit_inc);
						miss_q      <= sat_add(miss_q,
							{1'b0, outcome == OUT_MISS || outcome == OUT_EVICT});
						evict_q     <= sat_add(evict_q, {1'b0, outcome == OUT_EVICT});
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			op_s1  <= req.payload.op;
			tag_s1 <= req_tag;
			set_s1 <= req_set;
		end
		if (advance) begin
			rsp_q.outcome          <= outcome;
			rsp_q.modify_extra_hit <= (op_s1 == OP_MODIFY);
			rsp_q.hit_count        <= sat_add(hit_q, hit_inc);
			rsp_q.miss_count       <= sat_add(miss_q,
				{1'b0, outcome == OUT_MISS || outcome == OUT_EVICT});
			rsp_q.eviction_count   <= sat_add(evict_q, {1'b0, outcome == OUT_EVICT});
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

endmodule

@@ design/lsc_checker.sv @@
// ----------------------------------------------------------------------------
// lsc_checker: port-level checks for the LRU cache tag store
// Bound to the top level; watches request/result transfers over time.
// ----------------------------------------------------------------------------
module lsc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input lsc_pkg::outcome_t           rsp_outcome,
	input logic                        rsp_modify_extra_hit,
	input logic [lsc_pkg::COUNT_W-1:0] rsp_hit_count,
	input logic [lsc_pkg::COUNT_W-1:0] rsp_miss_count,
	input logic [lsc_pkg::COUNT_W-1:0] rsp_eviction_count
);
	import lsc_pkg::*;

	// one access in flight: no request taken in the cycle after a transfer
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken back to back");

	// a modify never reports an ignored outcome, and it has at least one hit
	a_modify_counted: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_modify_extra_hit |->
			rsp_outcome != OUT_IGNORED && rsp_hit_count != '0)
		else $error("modify flag inconsistent with outcome or hit total");

	// any miss is reflected in the miss total
	a_miss_counted: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_outcome == OUT_MISS || rsp_outcome == OUT_EVICT) |->
			rsp_miss_count != '0)
		else $error("miss reported with zero miss total");

	a_evict_counted: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_outcome == OUT_EVICT |-> rsp_eviction_count != '0)
		else $error("eviction reported with zero eviction total");

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_outcome) &&
			$stable(rsp_hit_count) && $stable(rsp_miss_count) &&
			$stable(rsp_eviction_count))
		else $error("stalled result changed");

endmodule

bind lru_set_assoc_cache_tags lsc_checker u_lsc_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.req_valid            (req.valid),
	.req_ready            (req.ready),
	.rsp_valid            (rsp.valid),
	.rsp_ready            (rsp.ready),
	.rsp_outcome          (rsp.payload.outcome),
	.rsp_modify_extra_hit (rsp.payload.modify_extra_hit),
	.rsp_hit_count        (rsp.payload.hit_count),
	.rsp_miss_count       (rsp.payload.miss_count),
	.rsp_eviction_count   (rsp.payload.eviction_count)
);
